>>> hdl/mist_pkg.sv
// shared types, register indexes and timeout table for the inactivity shutdown timer
`timescale 1ns / 1ps

package mist_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int SECONDS_W = 13;
   localparam int COUNT_W   = 12;
   localparam int TICK_W    = 6;
   localparam int SEL_W     = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SLEEP_ENABLE     = 2'd0,
      CSR_TIMEOUT_SELECT   = 2'd1,
      CSR_MOTION_THRESHOLD = 2'd2,
      CSR_TICKS_PER_SECOND = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                  sleep_enable;
      logic [SEL_W-1:0]      timeout_select;
      logic [SAMPLE_W-1:0]   motion_threshold;
      logic [TICK_W-1:0]     ticks_per_second;
   } cfg_type;

   typedef struct packed {
      logic signed [SECONDS_W-1:0] seconds_left;
      logic                        shutdown_request;
   } result_type;

   localparam logic [SECONDS_W-1:0] SECONDS_DISABLED = '1;

   function automatic logic [COUNT_W-1:0] timeout_value(input logic [SEL_W-1:0] sel);
      logic [COUNT_W-1:0] v;
      case (sel)
         3'd0:    v = 12'd10;
         3'd1:    v = 12'd30;
         3'd2:    v = 12'd60;
         3'd3:    v = 12'd120;
         3'd4:    v = 12'd300;
         3'd5:    v = 12'd600;
         3'd6:    v = 12'd1800;
         default: v = 12'd3600;
      endcase
      return v;
   endfunction

endpackage

>>> hdl/motion_inactivity_shutdown_timer.sv
// top level: input word register, timer core, result word register
//
//   port group   direction   carries
//   req_         in          gyro_x, gyro_y, gyro_z sample word
//   rsp_         out         seconds_left, shutdown_request result word
//   csr_         in          register index and write data
//
// a word waits in the input register until the result register is free, then moves
// into the result register; one word per cycle is sustained while the result register is not stalled
// the core state updates in the same cycle the word leaves the input register
// a stalled result register holds and backs up into the input register
// synchronous reset empties both registers, clears the timer state and loads the config defaults
`timescale 1ns / 1ps

module motion_inactivity_shutdown_timer #(
   parameter int TIMEOUT_ENTRIES = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [mist_pkg::SAMPLE_W-1:0]  req_gyro_x,
   input  logic signed [mist_pkg::SAMPLE_W-1:0]  req_gyro_y,
   input  logic signed [mist_pkg::SAMPLE_W-1:0]  req_gyro_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [mist_pkg::SECONDS_W-1:0] rsp_seconds_left,
   output logic                                  rsp_shutdown_request,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mist_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mist_pkg::CSR_DAT_W-1:0]        csr_data
);
   import mist_pkg::*;

   logic                       in_valid_ff, in_valid_in;
   logic signed [SAMPLE_W-1:0] in_x_ff, in_y_ff, in_z_ff;
   logic                       out_valid_ff, out_valid_in;
   result_type                 out_ff;
   result_type                 result;
   cfg_type                    cfg;
   logic                       out_free;
   logic                       fire;

   assign out_free     = !out_valid_ff || rsp_ready;
   assign fire         = in_valid_ff && out_free;
   assign req_ready    = !in_valid_ff || out_free;
   assign csr_ready    = 1'b1;
   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !out_free);
   assign out_valid_in = fire || (out_valid_ff && !rsp_ready);

   mist_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mist_core #(
      .TIMEOUT_ENTRIES (TIMEOUT_ENTRIES)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .gyro_x (in_x_ff),
      .gyro_y (in_y_ff),
      .gyro_z (in_z_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_x_ff <= req_gyro_x;
         in_y_ff <= req_gyro_y;
         in_z_ff <= req_gyro_z;
      end
      if (fire) begin
         out_ff <= result;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_seconds_left     = out_ff.seconds_left;
   assign rsp_shutdown_request = out_ff.shutdown_request;

endmodule

>>> hdl/mist_cfg.sv
// configuration register file
`timescale 1ns / 1ps

module mist_cfg (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   input  logic [mist_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mist_pkg::CSR_DAT_W-1:0]    csr_data,
   output mist_pkg::cfg_type                 cfg
);
   import mist_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_SLEEP_ENABLE:     cfg_in.sleep_enable     = csr_data[0];
            CSR_TIMEOUT_SELECT:   cfg_in.timeout_select   = csr_data[SEL_W-1:0];
            CSR_MOTION_THRESHOLD: cfg_in.motion_threshold = csr_data[SAMPLE_W-1:0];
            CSR_TICKS_PER_SECOND: cfg_in.ticks_per_second = csr_data[TICK_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sleep_enable     <= 1'b0;
         cfg_ff.timeout_select   <= '0;
         cfg_ff.motion_threshold <= 16'd20;
         cfg_ff.ticks_per_second <= 6'd50;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hdl/mist_core.sv
// countdown state, motion test and result computation
`timescale 1ns / 1ps

module mist_core #(
   parameter int TIMEOUT_ENTRIES = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                fire,
   input  logic signed [mist_pkg::SAMPLE_W-1:0] gyro_x,
   input  logic signed [mist_pkg::SAMPLE_W-1:0] gyro_y,
   input  logic signed [mist_pkg::SAMPLE_W-1:0] gyro_z,
   input  mist_pkg::cfg_type                   cfg,
   output mist_pkg::result_type                result
);
   import mist_pkg::*;

   logic                       started_ff, started_in;
   logic                       halted_ff, halted_in;
   logic [COUNT_W-1:0]         countdown_ff, countdown_in;
   logic [TICK_W-1:0]          tick_ff, tick_in;
   logic signed [SAMPLE_W-1:0] prev_ff [3];
   logic signed [SAMPLE_W-1:0] prev_in [3];

   logic signed [SAMPLE_W-1:0] cur [3];
   logic signed [SAMPLE_W:0]   diff [3];
   logic signed [SAMPLE_W:0]   thr;
   logic [SEL_W-1:0]           sel;
   logic [COUNT_W-1:0]         load;
   logic [TICK_W-1:0]          tick_inc;
   logic                       moved;
   logic                       active;

   assign cur[0] = gyro_x;
   assign cur[1] = gyro_y;
   assign cur[2] = gyro_z;
   assign thr    = $signed({1'b0, cfg.motion_threshold});
   assign active = fire && cfg.sleep_enable && !halted_ff;

   always_comb begin
      sel = cfg.timeout_select;
      if (int'(sel) >= TIMEOUT_ENTRIES) begin
         sel = SEL_W'(TIMEOUT_ENTRIES - 1);
      end
      load = timeout_value(sel);
   end

   always_comb begin
      moved = 1'b0;
      for (int i = 0; i < 3; i++) begin
         diff[i] = {prev_ff[i][SAMPLE_W-1], prev_ff[i]} - {cur[i][SAMPLE_W-1], cur[i]};
         if (diff[i] > thr) begin
            moved = 1'b1;
         end
      end
   end

   always_comb begin
      started_in   = started_ff;
      halted_in    = halted_ff;
      countdown_in = countdown_ff;
      tick_in      = tick_ff;
      tick_inc     = tick_ff + 1'b1;
      for (int i = 0; i < 3; i++) begin
         prev_in[i] = prev_ff[i];
      end
      if (active) begin
         if (!started_ff || moved) begin
            countdown_in = load;
            tick_in      = '0;
         end else if (tick_inc == cfg.ticks_per_second) begin
            countdown_in = countdown_ff - 1'b1;
            tick_in      = '0;
         end else begin
            tick_in = tick_inc;
         end
         started_in = 1'b1;
         for (int i = 0; i < 3; i++) begin
            prev_in[i] = cur[i];
         end
         if (countdown_in == '0) begin
            halted_in = 1'b1;
         end
      end
   end

   always_comb begin
      if (!cfg.sleep_enable) begin
         result.seconds_left     = SECONDS_DISABLED;
         result.shutdown_request = halted_ff;
      end else if (halted_ff) begin
         result.seconds_left     = '0;
         result.shutdown_request = 1'b1;
      end else begin
         result.seconds_left     = $signed({1'b0, countdown_in});
         result.shutdown_request = halted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         halted_ff    <= 1'b0;
         countdown_ff <= '0;
         tick_ff      <= '0;
         for (int i = 0; i < 3; i++) begin
            prev_ff[i] <= '0;
         end
      end else begin
         started_ff   <= started_in;
         halted_ff    <= halted_in;
         countdown_ff <= countdown_in;
         tick_ff      <= tick_in;
         for (int i = 0; i < 3; i++) begin
            prev_ff[i] <= prev_in[i];
         end
      end
   end

endmodule

>>> sim/tb.sv
// self-checking testbench for the motion inactivity shutdown timer
`timescale 1ns / 1ps

module tb;
   import mist_pkg::*;

   localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 16'sh8000;
   localparam int ROWS = 26;

   typedef struct packed {
      logic                        wr;
      csr_index_type               idx;
      logic [CSR_DAT_W-1:0]        data;
      logic signed [SAMPLE_W-1:0]  gx;
      logic signed [SAMPLE_W-1:0]  gy;
      logic signed [SAMPLE_W-1:0]  gz;
      logic                        typed;
      logic signed [SECONDS_W-1:0] sec;
      logic                        shut;
   } stim_row_type;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic signed [SAMPLE_W-1:0]  req_gyro_x;
   logic signed [SAMPLE_W-1:0]  req_gyro_y;
   logic signed [SAMPLE_W-1:0]  req_gyro_z;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic signed [SECONDS_W-1:0] rsp_seconds_left;
   logic                        rsp_shutdown_request;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [CSR_IDX_W-1:0]        csr_index;
   logic [CSR_DAT_W-1:0]        csr_data;

   // timer model state and register copies
   int unsigned timeout_s [8] = '{10, 30, 60, 2*60, 5*60, 10*60, 30*60, 60*60};
   logic                        en_cfg;
   logic [SEL_W-1:0]            sel_cfg;
   logic [SAMPLE_W-1:0]         thr_cfg;
   logic [TICK_W-1:0]           tps_cfg;
   logic                        started;
   logic                        halted;
   logic [COUNT_W-1:0]          secs;
   logic [TICK_W-1:0]           ticks;
   logic signed [SAMPLE_W-1:0]  last_smp [3];

   result_type pending_status [$];
   int  mismatches;
   int  samples_sent;
   int  tx_idle;
   int  rx_idle;
   bit  allow_halt;

   stim_row_type directed [ROWS] = '{
      '{1'b0, CSR_SLEEP_ENABLE, 16'd0, SMP_MAX, SMP_MIN, 16'sd0, 1'b1, -13'sd1, 1'b0},
      '{1'b1, CSR_SLEEP_ENABLE, 16'd1, 16'sd0, 16'sd0, 16'sd0, 1'b0, 13'sd0, 1'b0},
      '{1'b1, CSR_TIMEOUT_SELECT, 16'd7, 16'sd0, 16'sd0, 16'sd0, 1'b0, 13'sd0, 1'b0},
      '{1'b1, CSR_TICKS_PER_SECOND, 16'd1, 16'sd0, 16'sd0, 16'sd0, 1'b0, 13'sd0, 1'b0},
      '{1'b0, CSR_SLEEP_ENABLE, 16'd0, SMP_MIN, SMP_MIN, SMP_MIN, 1'b1, 13'sd3600, 1'b0},
      '{1'b0, CSR_SLEEP_ENABLE, 16'd0, SMP_MIN, SMP_MIN, SMP_MIN, 1'b1, 13'sd3599, 1'b0},
      '{1'b0, CSR_SLEEP_ENABLE, 16'd0, SMP_MAX, SMP_MAX, SMP_MAX, 1'b1, 13'sd3598, 1'b0},
      // drop equal to the threshold is not movement
      '{1'b0, CSR_SLEEP_ENABLE, 16'd0, 16'sd32747, SMP_MAX, SMP_MAX, 1'b1, 13'sd3597, 1'b0},
      '{1'b1, CSR_TIMEOUT_SELECT, 16'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 13'sd0, 1'b0},
      '{1'b0, CSR_SLEEP_ENABLE, 16'd0, 16'sd32747, SMP_MAX, 16'sd32746, 1'b1, 13'sd10, 1'b0},
      '{1'b1, CSR_MOTION_THRESHOLD, 16'hFFFF, 16'sd0, 16'sd0, 16'sd0, 1'b0, 13'sd0, 1'b0},
      '{1'b0, CSR_SLEEP_ENABLE, 16'd0, SMP_MIN, SMP_MIN, SMP_MIN, 1'b1, 13'sd9, 1'b0},
      '{1'b1, CSR_MOTION_THRESHOLD, 16'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 13'sd0, 1'b0},
      '{1'b0, CSR_SLEEP_ENABLE, 16'd0, SMP_MIN, SMP_MIN, SMP_MIN, 1'b1, 13'sd8, 1'b0},
      '{1'b0, CSR_SLEEP_ENABLE, 16'd0, SMP_MIN, -16'sd32767, SMP_MIN, 1'b1, 13'sd7, 1'b0},
      '{1'b0, CSR_SLEEP_ENABLE, 16'd0, SMP_MIN, SMP_MIN, SMP_MIN, 1'b1, 13'sd10, 1'b0},
      '{1'b1, CSR_TICKS_PER_SECOND, 16'd63, 16'sd0, 16'sd0, 16'sd0, 1'b0, 13'sd0, 1'b0},
      '{1'b0, CSR_SLEEP_ENABLE, 16'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 13'sd0, 1'b0},
      '{1'b1, CSR_TICKS_PER_SECOND, 16'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 13'sd0, 1'b0},
      '{1'b0, CSR_SLEEP_ENABLE, 16'd0, 16'sd1, 16'sd2, 16'sd3, 1'b0, 13'sd0, 1'b0},
      '{1'b1, CSR_SLEEP_ENABLE, 16'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 13'sd0, 1'b0},
      '{1'b0, CSR_SLEEP_ENABLE, 16'd0, 16'sd100, -16'sd100, 16'sd5, 1'b1, -13'sd1, 1'b0},
      '{1'b1, CSR_SLEEP_ENABLE, 16'd1, 16'sd0, 16'sd0, 16'sd0, 1'b0, 13'sd0, 1'b0},
      '{1'b0, CSR_SLEEP_ENABLE, 16'd0, -16'sd1, -16'sd1, -16'sd1, 1'b0, 13'sd0, 1'b0},
      '{1'b1, CSR_MOTION_THRESHOLD, 16'd20, 16'sd0, 16'sd0, 16'sd0, 1'b0, 13'sd0, 1'b0},
      '{1'b1, CSR_TICKS_PER_SECOND, 16'd50, 16'sd0, 16'sd0, 16'sd0, 1'b0, 13'sd0, 1'b0}
   };

   motion_inactivity_shutdown_timer uut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rx_idle);
   end

   always @(posedge clock) begin : check_words
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_status.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected word: seconds_left %0d shutdown_request %0b",
                        rsp_seconds_left, rsp_shutdown_request);
            end
         end else begin
            want = pending_status.pop_front();
            if (want.seconds_left !== rsp_seconds_left ||
                want.shutdown_request !== rsp_shutdown_request) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("word mismatch: seconds_left exp %0d got %0d, shutdown exp %0b got %0b",
                           want.seconds_left, rsp_seconds_left,
                           want.shutdown_request, rsp_shutdown_request);
               end
            end
         end
      end
   end

   task automatic advance_timer(input logic signed [SAMPLE_W-1:0] gx, gy, gz,
                                output result_type r);
      logic signed [SAMPLE_W-1:0] cur [3];
      bit moved;
      cur[0] = gx;
      cur[1] = gy;
      cur[2] = gz;
      if (!en_cfg) begin
         r.seconds_left = SECONDS_DISABLED;
         r.shutdown_request = halted;
      end else if (halted) begin
         r.seconds_left = '0;
         r.shutdown_request = 1'b1;
      end else begin
         if (started) begin
            moved = 1'b0;
            for (int k = 0; k < 3; k++) begin
               if (int'(last_smp[k]) - int'(cur[k]) > int'(thr_cfg)) moved = 1'b1;
            end
            if (moved) begin
               secs = COUNT_W'(timeout_s[sel_cfg]);
               ticks = '0;
            end else begin
               ticks = ticks + 1'b1;
               if (ticks == tps_cfg) begin
                  secs = secs - 1'b1;
                  ticks = '0;
               end
            end
         end else begin
            secs = COUNT_W'(timeout_s[sel_cfg]);
            ticks = '0;
            started = 1'b1;
         end
         for (int k = 0; k < 3; k++) last_smp[k] = cur[k];
         if (secs == '0) halted = 1'b1;
         r.seconds_left = {1'b0, secs};
         r.shutdown_request = halted;
      end
   endtask

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] gx, gy, gz,
                              input logic typed, input logic signed [SECONDS_W-1:0] sec,
                              input logic shut);
      result_type r;
      csr_valid <= 1'b0;
      while ($urandom_range(99) < tx_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_gyro_x <= gx;
      req_gyro_y <= gy;
      req_gyro_z <= gz;
      do @(posedge clock); while (!req_ready);
      advance_timer(gx, gy, gz, r);
      if (typed) begin
         r.seconds_left = sec;
         r.shutdown_request = shut;
      end
      pending_status.push_back(r);
      samples_sent++;
      @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DAT_W-1:0] val);
      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_SLEEP_ENABLE:     en_cfg = val[0];
         CSR_TIMEOUT_SELECT:   sel_cfg = val[SEL_W-1:0];
         CSR_MOTION_THRESHOLD: thr_cfg = val;
         CSR_TICKS_PER_SECOND: tps_cfg = val[TICK_W-1:0];
         default:              ;
      endcase
      @(negedge clock);
   endtask

   task automatic send_random();
      logic signed [SAMPLE_W-1:0] s [3];
      int v, rise, drop, lim, pick, ax;
      pick = $urandom_range(99);
      for (int k = 0; k < 3; k++) s[k] = last_smp[k];
      if (en_cfg && started && !halted && (allow_halt ? secs > 10 : secs <= 5)) begin
         // full-scale drop on x, climbing to the top first when the drop would fall short
         if (int'(last_smp[0]) + 32768 > int'(thr_cfg)) s[0] = SMP_MIN;
         else s[0] = SMP_MAX;
      end else if (pick < 20 && (!allow_halt || halted)) begin
         for (int k = 0; k < 3; k++) s[k] = SAMPLE_W'($urandom);
      end else if (pick < 40 && (!allow_halt || halted)) begin
         ax = $urandom_range(2);
         drop = $urandom_range(40);
         v = int'(last_smp[ax]) - int'(thr_cfg) - 1 - drop;
         if (v >= -32768) s[ax] = v[SAMPLE_W-1:0];
         else if (int'(last_smp[ax]) + 32768 > int'(thr_cfg)) s[ax] = SMP_MIN;
         else s[ax] = SMP_MAX;
      end else begin
         // still: every axis drops by no more than the threshold
         lim = (int'(thr_cfg) < 100) ? int'(thr_cfg) : 100;
         for (int k = 0; k < 3; k++) begin
            if ($urandom_range(9) == 0) begin
               drop = int'(thr_cfg);
               rise = 0;
            end else begin
               drop = $urandom_range(lim);
               rise = $urandom_range(100);
            end
            v = int'(last_smp[k]) + rise - drop;
            if (v < -32768) v = -32768;
            if (v > 32767) v = 32767;
            s[k] = v[SAMPLE_W-1:0];
         end
      end
      send_sample(s[0], s[1], s[2], 1'b0, '0, 1'b0);
   endtask

   initial begin
      logic                new_en;
      logic [SEL_W-1:0]    new_sel;
      logic [SAMPLE_W-1:0] new_thr;
      logic [TICK_W-1:0]   new_tps;
      reset = 1'b1;
      req_valid = 1'b0;
      req_gyro_x = '0;
      req_gyro_y = '0;
      req_gyro_z = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      en_cfg = 1'b0;
      sel_cfg = '0;
      thr_cfg = 16'd20;
      tps_cfg = 6'd50;
      started = 1'b0;
      halted = 1'b0;
      secs = '0;
      ticks = '0;
      for (int k = 0; k < 3; k++) last_smp[k] = '0;
      mismatches = 0;
      samples_sent = 0;
      tx_idle = 29;
      rx_idle = 69;
      allow_halt = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int r = 0; r < ROWS; r++) begin
         if (directed[r].wr) begin
            write_reg(directed[r].idx, directed[r].data);
         end else begin
            send_sample(directed[r].gx, directed[r].gy, directed[r].gz,
                        directed[r].typed, directed[r].sec, directed[r].shut);
         end
      end

      while (samples_sent < 1480) begin
         if (samples_sent < 500) begin
            tx_idle = 29;
            rx_idle = 69;
         end else if (samples_sent < 1000) begin
            tx_idle = 69;
            rx_idle = 29;
         end else begin
            tx_idle = 0;
            rx_idle = 0;
         end
         new_en = ($urandom_range(99) < 85);
         new_sel = SEL_W'($urandom_range(7));
         case ($urandom_range(3))
            0:       new_thr = '0;
            1:       new_thr = '1;
            2:       new_thr = SAMPLE_W'($urandom_range(300));
            default: new_thr = SAMPLE_W'($urandom);
         endcase
         case ($urandom_range(3))
            0:       new_tps = '0;
            1:       new_tps = 6'd1;
            2:       new_tps = 6'd63;
            default: new_tps = TICK_W'($urandom_range(63));
         endcase
         // no movement can be seen at full threshold, so keep the countdown slow
         if (new_thr == '1) new_tps = $urandom_range(1) ? 6'd0 : 6'd63;
         if (new_en != en_cfg || $urandom_range(2) == 0)
            write_reg(CSR_SLEEP_ENABLE, CSR_DAT_W'(new_en));
         if (new_sel != sel_cfg || $urandom_range(2) == 0)
            write_reg(CSR_TIMEOUT_SELECT, CSR_DAT_W'(new_sel));
         if (new_thr != thr_cfg || $urandom_range(2) == 0)
            write_reg(CSR_MOTION_THRESHOLD, new_thr);
         if (new_tps != tps_cfg || $urandom_range(2) == 0)
            write_reg(CSR_TICKS_PER_SECOND, CSR_DAT_W'(new_tps));
         repeat ($urandom_range(20, 80)) send_random();
      end

      // run the countdown out, then exercise the latched shutdown
      write_reg(CSR_SLEEP_ENABLE, 16'd1);
      write_reg(CSR_TIMEOUT_SELECT, 16'd0);
      write_reg(CSR_MOTION_THRESHOLD, CSR_DAT_W'($urandom_range(1000)));
      write_reg(CSR_TICKS_PER_SECOND, 16'd1);
      allow_halt = 1'b1;
      while (!halted) send_random();
      repeat (15) send_random();
      write_reg(CSR_SLEEP_ENABLE, 16'd0);
      repeat (10) send_random();
      write_reg(CSR_SLEEP_ENABLE, 16'd1);
      repeat (5) send_random();

      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("tb NOT OK");
      $finish;
   end

endmodule
